### design/mve_pkg.sv
// Shared widths, constants and controller/datapath interface types for the velocity estimator.
package mve_pkg;

  localparam int POS_W   = 32;
  localparam int VEL_W   = 32;
  localparam int STAMP_W = 48;
  localparam int CFG_W   = 32;
  localparam int AXES    = 3;
  localparam int AXIS_W  = 2;

  localparam int AVG_TAPS_DEF = 5;
  localparam int POS_BITS_DEF = 32;

  // Velocity scale from meters per microsecond to meters per second.
  localparam int SCALE_W   = 20;
  localparam int MUL_BIT_W = $clog2(SCALE_W);
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(1000000);

  localparam logic [CFG_W-1:0] PATH_INTERVAL_RST = CFG_W'(100000);

  typedef struct packed {
    logic                 first;
    logic                 load;
    logic                 mul_clr;
    logic                 mul_step;
    logic [MUL_BIT_W-1:0] mul_bit;
    logic                 raw_fault;
    logic                 raw_div;
    logic                 div_vel;
    logic                 div_avg;
    logic                 axis_done;
    logic                 out_load;
    logic [AXIS_W-1:0]    axis;
  } mve_cmd_t;

  typedef struct packed {
    logic fault;
    logic div_done;
    logic avg_done;
  } mve_status_t;

endpackage

### design/mocap_velocity_estimator.sv
// Top level of the motion capture velocity estimator.
// The first sample after reset sets the origin and gives no result; every later sample gives
// one result with the position relative to the origin, a 5-tap (AVG_TAPS) averaged velocity
// per axis in m/s, its timestamp, a path mark and a zero-elapsed-time fault flag. Samples are
// taken one at a time. Per axis there is a scale multiply, the velocity division in a restoring
// divider that gives one quotient bit per cycle over POS_BITS + 21 bits, and a reciprocal
// multiply for the average; the sample is taken in before the axes and the result loaded
// after them. A sample with zero elapsed time skips the multiply and the division. The result
// load waits while the previous result is still stalled. A finished result waits in the
// output register while the next sample is taken in. path_interval may be written at any
// time the block is idle.
module mocap_velocity_estimator import mve_pkg::*; #(
  parameter int AVG_TAPS = AVG_TAPS_DEF,
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic [STAMP_W-1:0]      stamp_us_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [POS_W-1:0] rel_x_o,
  output logic signed [POS_W-1:0] rel_y_o,
  output logic signed [POS_W-1:0] rel_z_o,
  output logic signed [VEL_W-1:0] vel_x_o,
  output logic signed [VEL_W-1:0] vel_y_o,
  output logic signed [VEL_W-1:0] vel_z_o,
  output logic [STAMP_W-1:0]      out_stamp_o,
  output logic                    path_mark_o,
  output logic                    time_fault_o
);

  mve_cmd_t    cmd;
  mve_status_t status;

  assign cfg_ready_o = 1'b1;

  mve_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mve_datapath #(
    .AVG_TAPS (AVG_TAPS),
    .POS_BITS (POS_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .stamp_us_i   (stamp_us_i),
    .rel_x_o      (rel_x_o),
    .rel_y_o      (rel_y_o),
    .rel_z_o      (rel_z_o),
    .vel_x_o      (vel_x_o),
    .vel_y_o      (vel_y_o),
    .vel_z_o      (vel_z_o),
    .out_stamp_o  (out_stamp_o),
    .path_mark_o  (path_mark_o),
    .time_fault_o (time_fault_o)
  );

endmodule

### design/mve_divider.sv
// Restoring divider, one quotient bit per cycle, used for the velocity division.
module mve_divider import mve_pkg::*; #(
  parameter int DIV_W = POS_BITS_DEF + 1 + SCALE_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [STAMP_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quotient_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIV_W-1:0]   quo_q, quo_d;
  logic [STAMP_W-1:0] rem_q, rem_d;
  logic [STAMP_W-1:0] divisor_q;
  logic [STAMP_W:0]   rem_s;
  logic               ge;

  always_comb begin
    rem_s = {rem_q, quo_q[DIV_W-1]};
    ge    = rem_s >= {1'b0, divisor_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? STAMP_W'(rem_s - {1'b0, divisor_q}) : rem_s[STAMP_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/mve_datapath.sv
// Datapath: origin and history registers, scale multiply, velocity divider, averaging, results.
module mve_datapath import mve_pkg::*; #(
  parameter int AVG_TAPS = AVG_TAPS_DEF,
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mve_cmd_t                  cmd_i,
  output mve_status_t               status_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic signed [POS_W-1:0]   pos_x_i,
  input  logic signed [POS_W-1:0]   pos_y_i,
  input  logic signed [POS_W-1:0]   pos_z_i,
  input  logic [STAMP_W-1:0]        stamp_us_i,
  output logic signed [POS_W-1:0]   rel_x_o,
  output logic signed [POS_W-1:0]   rel_y_o,
  output logic signed [POS_W-1:0]   rel_z_o,
  output logic signed [VEL_W-1:0]   vel_x_o,
  output logic signed [VEL_W-1:0]   vel_y_o,
  output logic signed [VEL_W-1:0]   vel_z_o,
  output logic [STAMP_W-1:0]        out_stamp_o,
  output logic                      path_mark_o,
  output logic                      time_fault_o
);

  localparam int HIST_LEN = AVG_TAPS - 1;
  localparam int DIFF_W   = POS_BITS + 1;
  localparam int DIV_W    = DIFF_W + SCALE_W;
  localparam int SUM_W    = VEL_W + $clog2(AVG_TAPS) + 1;

  // The average divides by a reciprocal: floor(x * AVG_RECIP / 2^AVG_SH) equals
  // floor(x / AVG_TAPS) for every x below 2^SUM_W. The product is built a chunk per cycle.
  localparam int AVG_SH     = SUM_W + $clog2(AVG_TAPS);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int CHUNK_W    = 12;
  localparam int AVG_CHUNKS = (SUM_W + CHUNK_W - 1) / CHUNK_W;
  localparam int AVG_X_W    = AVG_CHUNKS * CHUNK_W;
  localparam int ACC_W      = AVG_X_W + RECIP_W;
  localparam int PP_W       = CHUNK_W + RECIP_W;
  localparam int AVG_CNT_W  = $clog2(AVG_CHUNKS + 1);
  localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SH) + 64'(AVG_TAPS - 1)) / 64'(AVG_TAPS));

  logic [CFG_W-1:0]           path_interval_q;
  logic signed [POS_BITS-1:0] origin_q   [AXES];
  logic signed [POS_BITS-1:0] prev_rel_q [AXES];
  logic signed [POS_BITS-1:0] rel_q      [AXES];
  logic signed [POS_BITS-1:0] pos_in     [AXES];
  logic [STAMP_W-1:0]         prev_stamp_q, last_mark_q, stamp_q, dt_q;
  logic [DIV_W-1:0]           prod_q;
  logic signed [VEL_W-1:0]    raw_q, raw_d;
  logic                       tot_neg_q;
  logic signed [VEL_W-1:0]    hist_q   [AXES][HIST_LEN];
  logic signed [SUM_W-1:0]    runsum_q [AXES];
  logic signed [VEL_W-1:0]    vel_q    [AXES];
  logic signed [VEL_W-1:0]    vel_out_q [AXES];
  logic signed [POS_W-1:0]    rel_out_q [AXES];
  logic [STAMP_W-1:0]         out_stamp_q;
  logic                       mark_q, fault_q;
  logic [AVG_X_W-1:0]         avg_x_q;
  logic [ACC_W-1:0]           avg_acc_q;
  logic [AVG_CNT_W-1:0]       avg_cnt_q;
  logic                       avg_busy_q, avg_done_q;

  logic signed [DIFF_W-1:0] diff;
  logic                     diff_neg;
  logic [DIFF_W-1:0]        diff_mag;
  logic [VEL_W:0]           lim, qsat, qneg, avg_mag, avg_neg;
  logic signed [SUM_W-1:0]  tot;
  logic                     tot_neg;
  logic [SUM_W-1:0]         tot_mag;
  logic [PP_W-1:0]          avg_pp;
  logic [DIV_W-1:0]         quotient;
  logic [STAMP_W-1:0]       since_mark;
  logic                     mark;
  logic                     fault;

  assign pos_in[0] = POS_BITS'(pos_x_i);
  assign pos_in[1] = POS_BITS'(pos_y_i);
  assign pos_in[2] = POS_BITS'(pos_z_i);

  assign fault = (dt_q == '0);

  always_comb begin
    diff     = DIFF_W'(rel_q[cmd_i.axis]) - DIFF_W'(prev_rel_q[cmd_i.axis]);
    diff_neg = diff[DIFF_W-1];
    diff_mag = diff_neg ? DIFF_W'(-diff) : DIFF_W'(diff);

    // Largest magnitude the raw velocity may take for this sign.
    lim  = {1'b0, 1'b1, {(VEL_W-1){1'b0}}} - {{VEL_W{1'b0}}, ~diff_neg};
    qsat = (quotient > DIV_W'(lim)) ? lim : quotient[VEL_W:0];
    qneg = (VEL_W+1)'(0) - qsat;

    raw_d = raw_q;
    if (cmd_i.raw_fault) begin
      if (diff_neg) begin
        raw_d = {1'b1, {(VEL_W-1){1'b0}}};
      end else if (diff == '0) begin
        raw_d = '0;
      end else begin
        raw_d = {1'b0, {(VEL_W-1){1'b1}}};
      end
    end else if (cmd_i.raw_div) begin
      raw_d = diff_neg ? qneg[VEL_W-1:0] : qsat[VEL_W-1:0];
    end

    tot     = SUM_W'(raw_q) + runsum_q[cmd_i.axis];
    tot_neg = tot[SUM_W-1];
    tot_mag = tot_neg ? SUM_W'(-tot) : SUM_W'(tot);

    avg_pp  = PP_W'(avg_x_q[AVG_X_W-1 -: CHUNK_W]) * PP_W'(AVG_RECIP);
    avg_mag = avg_acc_q[AVG_SH +: VEL_W+1];
    avg_neg = (VEL_W+1)'(0) - avg_mag;

    since_mark = stamp_q - last_mark_q;
    mark       = since_mark > STAMP_W'(path_interval_q);
  end

  mve_divider #(
    .DIV_W (DIV_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_vel),
    .dividend_i (prod_q),
    .divisor_i  (dt_q),
    .done_o     (status_o.div_done),
    .quotient_o (quotient)
  );

  assign status_o.fault    = fault;
  assign status_o.avg_done = avg_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_interval_q <= PATH_INTERVAL_RST;
      prev_stamp_q    <= '0;
      last_mark_q     <= '0;
      avg_busy_q      <= 1'b0;
      avg_done_q      <= 1'b0;
      avg_cnt_q       <= '0;
      for (int a = 0; a < AXES; a++) begin
        origin_q[a]   <= '0;
        prev_rel_q[a] <= '0;
        runsum_q[a]   <= '0;
        for (int k = 0; k < HIST_LEN; k++) begin
          hist_q[a][k] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        path_interval_q <= cfg_data_i;
      end
      if (cmd_i.first) begin
        prev_stamp_q <= stamp_us_i;
        for (int a = 0; a < AXES; a++) begin
          origin_q[a]   <= pos_in[a];
          prev_rel_q[a] <= '0;
        end
      end
      if (cmd_i.load) begin
        prev_stamp_q <= stamp_us_i;
      end
      avg_done_q <= 1'b0;
      if (cmd_i.div_avg) begin
        avg_busy_q <= 1'b1;
        avg_cnt_q  <= AVG_CNT_W'(AVG_CHUNKS);
      end else if (avg_busy_q) begin
        avg_cnt_q <= avg_cnt_q - AVG_CNT_W'(1);
        if (avg_cnt_q == AVG_CNT_W'(1)) begin
          avg_busy_q <= 1'b0;
          avg_done_q <= 1'b1;
        end
      end
      if (cmd_i.axis_done) begin
        for (int a = 0; a < AXES; a++) begin
          if (AXIS_W'(a) == cmd_i.axis) begin
            prev_rel_q[a] <= rel_q[a];
            runsum_q[a]   <= runsum_q[a] + SUM_W'(raw_q) - SUM_W'(hist_q[a][HIST_LEN-1]);
            for (int k = HIST_LEN - 1; k > 0; k--) begin
              hist_q[a][k] <= hist_q[a][k-1];
            end
            hist_q[a][0] <= raw_q;
          end
        end
      end
      if (cmd_i.out_load && mark) begin
        last_mark_q <= stamp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stamp_q <= stamp_us_i;
      dt_q    <= stamp_us_i - prev_stamp_q;
      for (int a = 0; a < AXES; a++) begin
        rel_q[a] <= pos_in[a] - origin_q[a];
      end
    end
    if (cmd_i.mul_clr) begin
      prod_q <= '0;
    end else if (cmd_i.mul_step) begin
      // Scale multiply, one constant bit per cycle, most significant first.
      prod_q <= (prod_q << 1) + (SCALE[cmd_i.mul_bit] ? DIV_W'(diff_mag) : '0);
    end
    raw_q <= raw_d;
    if (cmd_i.div_avg) begin
      tot_neg_q <= tot_neg;
      avg_x_q   <= AVG_X_W'(tot_mag);
      avg_acc_q <= '0;
    end else if (avg_busy_q) begin
      // Most significant chunk first, so the accumulated product shifts up each cycle.
      avg_x_q   <= avg_x_q << CHUNK_W;
      avg_acc_q <= (avg_acc_q << CHUNK_W) + ACC_W'(avg_pp);
    end
    if (cmd_i.axis_done) begin
      for (int a = 0; a < AXES; a++) begin
        if (AXIS_W'(a) == cmd_i.axis) begin
          vel_q[a] <= tot_neg_q ? avg_neg[VEL_W-1:0] : avg_mag[VEL_W-1:0];
        end
      end
    end
    if (cmd_i.out_load) begin
      out_stamp_q <= stamp_q;
      mark_q      <= mark;
      fault_q     <= fault;
      for (int a = 0; a < AXES; a++) begin
        rel_out_q[a] <= POS_W'(rel_q[a]);
        vel_out_q[a] <= vel_q[a];
      end
    end
  end

  assign rel_x_o      = rel_out_q[0];
  assign rel_y_o      = rel_out_q[1];
  assign rel_z_o      = rel_out_q[2];
  assign vel_x_o      = vel_out_q[0];
  assign vel_y_o      = vel_out_q[1];
  assign vel_z_o      = vel_out_q[2];
  assign out_stamp_o  = out_stamp_q;
  assign path_mark_o  = mark_q;
  assign time_fault_o = fault_q;

endmodule

### design/mve_ctrl.sv
// Controller: three axes, each multiply and divide (both skipped on fault), then average.
module mve_ctrl import mve_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  mve_status_t status_i,
  output mve_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DGO   = 3'd3;
  localparam logic [2:0] S_DIV1  = 3'd4;
  localparam logic [2:0] S_AVG   = 3'd5;
  localparam logic [2:0] S_DIV2  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  logic [2:0]           state_q, state_d;
  logic                 started_q, started_d;
  logic [AXIS_W-1:0]    axis_q, axis_d;
  logic [MUL_BIT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.axis    = axis_q;
    cmd_o.mul_bit = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!started_q) begin
            cmd_o.first = 1'b1;
            started_d   = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            axis_d     = '0;
            state_d    = S_START;
          end
        end
      end
      S_START: begin
        if (status_i.fault) begin
          cmd_o.raw_fault = 1'b1;
          state_d         = S_AVG;
        end else begin
          cmd_o.mul_clr = 1'b1;
          cnt_d         = MUL_BIT_W'(SCALE_W - 1);
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DGO;
        end else begin
          cnt_d = cnt_q - MUL_BIT_W'(1);
        end
      end
      S_DGO: begin
        cmd_o.div_vel = 1'b1;
        state_d       = S_DIV1;
      end
      S_DIV1: begin
        if (status_i.div_done) begin
          cmd_o.raw_div = 1'b1;
          state_d       = S_AVG;
        end
      end
      S_AVG: begin
        cmd_o.div_avg = 1'b1;
        state_d       = S_DIV2;
      end
      S_DIV2: begin
        if (status_i.avg_done) begin
          cmd_o.axis_done = 1'b1;
          if (axis_q == LAST_AXIS) begin
            state_d = S_OUT;
          end else begin
            axis_d  = axis_q + AXIS_W'(1);
            state_d = S_START;
          end
        end
      end
      S_OUT: begin
        // The result register is reused only once the previous result is transferred.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      axis_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### tb/sv/tb.sv
// Testbench for the motion capture velocity estimator: directed table, random samples, checks.
module tb import mve_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int TAPS = 5;

  typedef enum int {IDLE_SEND, IDLE_RECV, IDLE_NONE} idle_mode_e;
  typedef enum int {ROW_ORIGIN, ROW_TYPED, ROW_PREDICT} row_kind_e;

  typedef struct {
    logic signed [POS_W-1:0] rel [AXES];
    logic signed [VEL_W-1:0] vel [AXES];
    logic [STAMP_W-1:0]      stamp;
    logic                    mark;
    logic                    fault;
  } motion_t;

  typedef struct {
    row_kind_e               kind;
    logic signed [POS_W-1:0] pos [AXES];
    logic [STAMP_W-1:0]      stamp;
    motion_t                 want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [POS_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [STAMP_W-1:0] stamp_us_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [POS_W-1:0] rel_x_o, rel_y_o, rel_z_o;
  logic signed [VEL_W-1:0] vel_x_o, vel_y_o, vel_z_o;
  logic [STAMP_W-1:0] out_stamp_o;
  logic path_mark_o, time_fault_o;

  mocap_velocity_estimator dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state.
  logic [CFG_W-1:0]        mark_interval;
  bit                      have_origin;
  logic signed [POS_W-1:0] origin [AXES];
  logic signed [POS_W-1:0] last_rel [AXES];
  logic [STAMP_W-1:0]      last_stamp;
  logic [STAMP_W-1:0]      mark_stamp;
  longint                  rate_hist [AXES][TAPS-1];

  motion_t    pending_motion [$];
  int         errors = 0;
  int         cycles = 0;
  idle_mode_e idle_mode = IDLE_SEND;
  int         hold_off = 0;

  function automatic logic signed [VEL_W-1:0] scaled_rate(longint diff, logic [STAMP_W-1:0] dt);
    logic [63:0] mag, lim, prod, quo, rem, q, dt64;
    bit neg;
    neg  = diff < 0;
    mag  = neg ? -diff : diff;
    lim  = neg ? 64'd2147483648 : 64'd2147483647;
    dt64 = {16'b0, dt};
    prod = mag * 64'd15625;
    quo  = prod / dt64;
    rem  = prod % dt64;
    if (quo >= 64'h1_0000_0000) q = lim;
    else q = quo * 64 + (rem * 64) / dt64;
    if (q > lim) q = lim;
    return neg ? VEL_W'(-q) : VEL_W'(q);
  endfunction

  // Advances the predictor by one sample; returns 1 when the sample gives a result.
  function automatic bit track_sample(logic signed [POS_W-1:0] pos [AXES],
                                      logic [STAMP_W-1:0] stamp, output motion_t m);
    logic [STAMP_W-1:0] dt, since;
    logic signed [POS_W-1:0] rel;
    longint diff, rate, sum;
    m = '{default: '0};
    if (!have_origin) begin
      have_origin = 1'b1;
      foreach (origin[a]) begin
        origin[a] = pos[a];
        last_rel[a] = '0;
      end
      last_stamp = stamp;
      return 1'b0;
    end
    dt = stamp - last_stamp;
    m.fault = (dt == '0);
    for (int a = 0; a < AXES; a++) begin
      rel = pos[a] - origin[a];
      diff = longint'(rel) - longint'(last_rel[a]);
      if (m.fault) rate = diff > 0 ? 64'sd2147483647 : (diff < 0 ? -64'sd2147483648 : 0);
      else rate = longint'(scaled_rate(diff, dt));
      sum = rate;
      for (int k = 0; k < TAPS - 1; k++) sum += rate_hist[a][k];
      for (int k = TAPS - 2; k > 0; k--) rate_hist[a][k] = rate_hist[a][k-1];
      rate_hist[a][0] = rate;
      last_rel[a] = rel;
      m.rel[a] = rel;
      m.vel[a] = VEL_W'(sum / TAPS);
    end
    last_stamp = stamp;
    since = stamp - mark_stamp;
    m.mark = since > {16'b0, mark_interval};
    if (m.mark) mark_stamp = stamp;
    m.stamp = stamp;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    motion_t m;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_motion.size() == 0) begin
        report_mismatch("result transfer count", 1, 0);
      end else begin
        m = pending_motion.pop_front();
        if (rel_x_o !== m.rel[0]) report_mismatch("rel_x", rel_x_o, m.rel[0]);
        if (rel_y_o !== m.rel[1]) report_mismatch("rel_y", rel_y_o, m.rel[1]);
        if (rel_z_o !== m.rel[2]) report_mismatch("rel_z", rel_z_o, m.rel[2]);
        if (vel_x_o !== m.vel[0]) report_mismatch("vel_x", vel_x_o, m.vel[0]);
        if (vel_y_o !== m.vel[1]) report_mismatch("vel_y", vel_y_o, m.vel[1]);
        if (vel_z_o !== m.vel[2]) report_mismatch("vel_z", vel_z_o, m.vel[2]);
        if (out_stamp_o !== m.stamp) report_mismatch("out_stamp", out_stamp_o, m.stamp);
        if (path_mark_o !== m.mark) report_mismatch("path_mark", path_mark_o, m.mark);
        if (time_fault_o !== m.fault) report_mismatch("time_fault", time_fault_o, m.fault);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls by mode, or a long hold-off counted here.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall_i = 1'b1;
    end else begin
      case (idle_mode)
        IDLE_SEND: out_stall_i = ($urandom_range(0, 99) < 71);
        IDLE_RECV: out_stall_i = ($urandom_range(0, 99) < 33);
        default:   out_stall_i = 1'b0;
      endcase
    end
  end

  task automatic send_sample(logic signed [POS_W-1:0] pos [AXES], logic [STAMP_W-1:0] stamp,
                             row_kind_e kind, motion_t want);
    int pct;
    motion_t m;
    pct = (idle_mode == IDLE_SEND) ? 33 : (idle_mode == IDLE_RECV) ? 71 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pos_x_i = pos[0];
    pos_y_i = pos[1];
    pos_z_i = pos[2];
    stamp_us_i = stamp;
    do @(posedge clk_i); while (in_stall_o);
    if (track_sample(pos, stamp, m)) begin
      if (kind == ROW_TYPED) pending_motion.insert(pending_motion.size(), want);
      else pending_motion.insert(pending_motion.size(), m);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Waits until every result is in, then lets the block settle before a register write.
  task automatic write_interval(logic [CFG_W-1:0] value);
    while (pending_motion.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mark_interval = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  stim_row_t rows [12];

  initial begin
    logic signed [POS_W-1:0] pos [AXES];
    logic signed [POS_W-1:0] cur [AXES];
    logic [STAMP_W-1:0] stamp;
    motion_t none;
    int pick;

    none = '{default: '0};
    mark_interval = PATH_INTERVAL_RST;
    have_origin = 1'b0;
    last_stamp = '0;
    mark_stamp = '0;
    foreach (origin[a]) begin
      origin[a] = '0;
      last_rel[a] = '0;
      foreach (rate_hist[a][k]) rate_hist[a][k] = 0;
    end

    rows[0] = '{ROW_ORIGIN, '{32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 48'd1000, none};
    // Zero elapsed time right after the origin: velocities saturate, then divide by the taps.
    rows[1] = '{ROW_TYPED, '{32'hC001_0000, 32'h7FFE_FFFF, 32'h8000_0000}, 48'd1000,
                '{'{32'h0001_0000, 32'hFFFF_0000, 32'h0}, '{32'sd429496729, -32'sd429496729, 32'sd0},
                  48'd1000, 1'b0, 1'b0}};
    rows[1].want.fault = 1'b1;
    rows[2] = '{ROW_PREDICT, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 48'd1001, none};
    rows[3] = '{ROW_PREDICT, '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 48'd1002, none};
    rows[4] = '{ROW_PREDICT, '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 48'd1002, none};
    rows[5] = '{ROW_PREDICT, '{32'h0, 32'h0, 32'h0}, 48'hFFFF_FFFF_FFFF, none};
    rows[6] = '{ROW_PREDICT, '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0}, 48'd4, none};
    rows[7] = '{ROW_PREDICT, '{32'h0001_0000, 32'h0, 32'h5555_5555}, 48'd200004, none};
    rows[8] = '{ROW_PREDICT, '{32'h0002_0000, 32'h0, 32'hAAAA_AAAA}, 48'd300005, none};
    rows[9] = '{ROW_PREDICT, '{32'h0002_0001, 32'h1, 32'hAAAA_AAAA}, 48'h8000_0000_0000, none};
    rows[10] = '{ROW_PREDICT, '{32'h0002_0000, 32'h0, 32'hAAAA_AAAB}, 48'h8000_0000_0001, none};
    rows[11] = '{ROW_PREDICT, '{32'h0010_0000, 32'hFFF0_0000, 32'h0}, 48'h8000_0001_0000, none};

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_sample(rows[i].pos, rows[i].stamp, rows[i].kind, rows[i].want);
    cur = rows[11].pos;
    stamp = rows[11].stamp;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_interval('0);
        1: write_interval(32'hFFFF_FFFF);
        2: write_interval(32'd5000);
        default: write_interval(PATH_INTERVAL_RST);
      endcase
      idle_mode = (phase == 0) ? IDLE_SEND : (phase == 1) ? IDLE_RECV : IDLE_NONE;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // The long hold-off lets results pile up so the block stalls its input.
        if (phase == 3 && i == 20) hold_off = 3000;
        pick = $urandom_range(0, 99);
        pos = cur;
        if (pick < 3) begin
          // Same stamp, no movement.
        end else if (pick < 7) begin
          foreach (pos[a]) pos[a] = cur[a] + $signed($urandom_range(0, 2000)) - 1000;
        end else if (pick < 12) begin
          foreach (pos[a]) pos[a] = $urandom();
          stamp = STAMP_W'({$urandom(), $urandom()});
        end else if (pick < 16) begin
          foreach (pos[a]) pos[a] = cur[a] + $signed($urandom());
          stamp = stamp + $urandom_range(1, 3);
        end else begin
          foreach (pos[a]) pos[a] = cur[a] + $signed($urandom_range(0, 2 << 20)) - (1 << 20);
          stamp = stamp + $urandom_range(1, 50000);
        end
        send_sample(pos, stamp, ROW_PREDICT, none);
        cur = pos;
      end
    end

    while (pending_motion.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
